/* hdl/gwp_pkg.sv */
// Package for the grid word path search unit.
// Holds the sizes, command and register codes, and the word types of both channels.
// Depends on nothing.
package gwp_pkg;

  localparam int ROWS_MAX  = 8;
  localparam int COLS_MAX  = 8;
  localparam int WORD_MAX  = 16;

  localparam int ROW_W     = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int COL_W     = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int CELL_W    = ROW_W + COL_W;
  localparam int CELL_NUM  = 1 << CELL_W;
  localparam int WPOS_W    = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
  localparam int LEN_W     = 5;
  localparam int DIM_W     = 4;
  localparam int CHAR_W    = 8;
  localparam int DIR_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 4;

  localparam logic [1:0] CMD_LOAD_CELL   = 2'd0;
  localparam logic [1:0] CMD_LOAD_LETTER = 2'd1;
  localparam logic [1:0] CMD_SEARCH      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] cell_row;
    logic [2:0] cell_col;
    logic [7:0] letter;
    logic [3:0] word_position;
    logic [4:0] word_length;
  } cmd_t;

  typedef struct packed {
    logic found;
  } res_t;

endpackage

/* hdl/gwp_ifs.sv */
// Valid/ready channel interfaces of the grid word path search unit.
// Depends on gwp_pkg for the word types.
interface gwp_cmd_if;
  logic          valid;
  logic          ready;
  gwp_pkg::cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gwp_res_if;
  logic          valid;
  logic          ready;
  gwp_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/grid_word_path_search_unit.sv */
// Grid word path search unit: grid, word and visited stores, backtracking search sequencer.
// Depends on gwp_pkg and on the channel interfaces in gwp_ifs.sv.
//
// Load words (a grid cell or a word letter) are taken one per cycle and give no
// result; a search word gives one result word carrying found. While a search
// runs the command channel is not ready. A search reads and then compares every start
// cell tried, steps to and then compares every in-grid neighbour tried, skips every
// off-grid neighbour and pops in the step state, and hands over the result, later
// while an earlier result word still waits. A search that finds the word passes the
// step state once more on the completed path, then releases its cells in the visited
// map letter by letter. A search that ends before the walk (empty word, empty grid or
// word longer than the store) goes straight to handing over the result. The grid
// memory has a single read port, which the sequencer uses once per candidate cell.
// After reset the unit clears every cell of the visited map before it takes its first
// word. Grid size registers are written through the plain configuration port by the
// user, who must do so only while the unit is idle; the unit does not enforce this.
module grid_word_path_search_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gwp_cmd_if.sink                         cmd_i,
  gwp_res_if.source                       res_o,
  input  logic                            cfg_we_i,
  input  logic [gwp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gwp_pkg::CFG_W-1:0]       cfg_data_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START_RD,
    ST_START_CMP,
    ST_STEP,
    ST_CMP,
    ST_UNWIND,
    ST_DONE
  } state_e;

  localparam int CELL_W = gwp_pkg::CELL_W;
  localparam int ROW_W  = gwp_pkg::ROW_W;
  localparam int COL_W  = gwp_pkg::COL_W;
  localparam int DIM_W  = gwp_pkg::DIM_W;
  localparam int WPOS_W = gwp_pkg::WPOS_W;
  localparam int LEN_W  = gwp_pkg::LEN_W;
  localparam int DIR_W  = gwp_pkg::DIR_W;
  localparam int CHAR_W = gwp_pkg::CHAR_W;

  state_e                       state_q;
  logic [DIM_W-1:0]             rows_q, cols_q;
  logic [LEN_W-1:0]             len_q, depth_q;
  logic [ROW_W-1:0]             r_q;
  logic [COL_W-1:0]             c_q;
  logic [CELL_W-1:0]            next_q;
  logic [CELL_W-1:0]            clr_q;
  logic                         found_q;
  logic                         res_valid_q, res_found_q;

  logic [CELL_W-1:0]            stk_cell_q [gwp_pkg::WORD_MAX];
  logic [DIR_W-1:0]             stk_dir_q  [gwp_pkg::WORD_MAX];

  logic [CHAR_W-1:0]            grid_mem [gwp_pkg::CELL_NUM];
  logic [CHAR_W-1:0]            word_mem [gwp_pkg::WORD_MAX];
  logic                         vis_mem  [gwp_pkg::CELL_NUM];
  logic [CHAR_W-1:0]            grid_rd_q, word_rd_q;
  logic                         vis_rd_q;
  logic [CELL_W-1:0]            grid_ra;
  logic [WPOS_W-1:0]            word_ra;
  logic                         vis_we, vis_wd;
  logic [CELL_W-1:0]            vis_wa;

  logic                         cmd_acc;
  logic [DIM_W-1:0]             rows_eff, cols_eff;
  logic [CELL_W-1:0]            start_cell;
  logic                         start_last;
  logic [ROW_W-1:0]             adv_r;
  logic [COL_W-1:0]             adv_c;
  logic [WPOS_W-1:0]            top_idx;
  logic [CELL_W-1:0]            top_cell;
  logic [DIR_W-1:0]             top_dir;
  logic [ROW_W-1:0]             top_r, nb_r;
  logic [COL_W-1:0]             top_c, nb_c;
  logic                         nb_ok;
  logic [CELL_W-1:0]            nb_cell;
  logic                         match;
  logic                         word_done;
  logic                         push;

  assign cmd_acc      = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready  = (state_q == ST_IDLE);
  assign res_o.valid  = res_valid_q;
  assign res_o.data.found = res_found_q;

  assign rows_eff = (rows_q > DIM_W'(gwp_pkg::ROWS_MAX)) ? DIM_W'(gwp_pkg::ROWS_MAX) : rows_q;
  assign cols_eff = (cols_q > DIM_W'(gwp_pkg::COLS_MAX)) ? DIM_W'(gwp_pkg::COLS_MAX) : cols_q;

  // Row-major walk over start cells
  assign start_cell = {r_q, c_q};
  always_comb begin
    adv_r      = r_q;
    adv_c      = c_q + COL_W'(1);
    start_last = 1'b0;
    if ((DIM_W'(c_q) + DIM_W'(1)) >= cols_eff) begin
      adv_c = '0;
      adv_r = r_q + ROW_W'(1);
      start_last = ((DIM_W'(r_q) + DIM_W'(1)) >= rows_eff);
    end
  end

  assign top_idx  = WPOS_W'(depth_q - LEN_W'(1));
  assign top_cell = stk_cell_q[top_idx];
  assign top_dir  = stk_dir_q[top_idx];
  assign top_r    = top_cell[CELL_W-1:COL_W];
  assign top_c    = top_cell[COL_W-1:0];

  always_comb begin
    nb_r  = top_r;
    nb_c  = top_c;
    nb_ok = 1'b0;
    case (top_dir)
      gwp_pkg::DIR_UP: begin
        nb_ok = (top_r != '0);
        nb_r  = top_r - ROW_W'(1);
      end
      gwp_pkg::DIR_DOWN: begin
        nb_ok = (DIM_W'(top_r) + DIM_W'(1)) < rows_eff;
        nb_r  = top_r + ROW_W'(1);
      end
      gwp_pkg::DIR_LEFT: begin
        nb_ok = (top_c != '0);
        nb_c  = top_c - COL_W'(1);
      end
      gwp_pkg::DIR_RIGHT: begin
        nb_ok = (DIM_W'(top_c) + DIM_W'(1)) < cols_eff;
        nb_c  = top_c + COL_W'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end
  assign nb_cell = {nb_r, nb_c};

  assign grid_ra   = (state_q == ST_START_RD) ? start_cell : nb_cell;
  assign word_ra   = (state_q == ST_START_RD) ? '0 : depth_q[WPOS_W-1:0];
  assign match     = (grid_rd_q == word_rd_q);
  assign word_done = (depth_q >= len_q);
  assign push      = !vis_rd_q && match;

  always_ff @(posedge clk_i) begin
    if (cmd_acc && cmd_i.data.command == gwp_pkg::CMD_LOAD_CELL &&
        cmd_i.data.cell_row < gwp_pkg::ROWS_MAX && cmd_i.data.cell_col < gwp_pkg::COLS_MAX) begin
      grid_mem[{cmd_i.data.cell_row[ROW_W-1:0], cmd_i.data.cell_col[COL_W-1:0]}] <=
        cmd_i.data.letter;
    end
    grid_rd_q <= grid_mem[grid_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc && cmd_i.data.command == gwp_pkg::CMD_LOAD_LETTER &&
        cmd_i.data.word_position < gwp_pkg::WORD_MAX) begin
      word_mem[cmd_i.data.word_position[WPOS_W-1:0]] <= cmd_i.data.letter;
    end
    word_rd_q <= word_mem[word_ra];
  end

  always_comb begin
    vis_we = 1'b0;
    vis_wa = top_cell;
    vis_wd = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        vis_we = 1'b1;
        vis_wa = clr_q;
      end
      ST_START_CMP: begin
        vis_we = match;
        vis_wa = start_cell;
        vis_wd = 1'b1;
      end
      ST_STEP: begin
        vis_we = !word_done && top_dir == gwp_pkg::DIR_DONE;
        vis_wa = top_cell;
      end
      ST_CMP: begin
        vis_we = push;
        vis_wa = next_q;
        vis_wd = 1'b1;
      end
      ST_UNWIND: begin
        vis_we = 1'b1;
        vis_wa = top_cell;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_rd_q <= vis_mem[nb_cell];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_START_CMP: begin
        if (match) begin
          stk_cell_q[0] <= start_cell;
          stk_dir_q[0]  <= gwp_pkg::DIR_UP;
        end
      end
      ST_STEP: begin
        if (!word_done && top_dir != gwp_pkg::DIR_DONE) begin
          stk_dir_q[top_idx] <= top_dir + DIR_W'(1);
        end
      end
      ST_CMP: begin
        if (push) begin
          stk_cell_q[depth_q[WPOS_W-1:0]] <= next_q;
          stk_dir_q[depth_q[WPOS_W-1:0]]  <= gwp_pkg::DIR_UP;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rows_q      <= DIM_W'(gwp_pkg::ROWS_MAX);
      cols_q      <= DIM_W'(gwp_pkg::COLS_MAX);
      len_q       <= '0;
      depth_q     <= '0;
      r_q         <= '0;
      c_q         <= '0;
      next_q      <= '0;
      clr_q       <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gwp_pkg::REG_GRID_ROWS: rows_q <= cfg_data_i;
          gwp_pkg::REG_GRID_COLS: cols_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (res_valid_q && res_o.ready && state_q != ST_DONE) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + CELL_W'(1);
          if (clr_q == {CELL_W{1'b1}}) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_acc && cmd_i.data.command == gwp_pkg::CMD_SEARCH) begin
            depth_q   <= '0;
            len_q     <= cmd_i.data.word_length;
            r_q       <= '0;
            c_q       <= '0;
            if (rows_eff == '0 || cols_eff == '0 ||
                cmd_i.data.word_length > gwp_pkg::WORD_MAX) begin
              found_q <= 1'b0;
              state_q <= ST_DONE;
            end else if (cmd_i.data.word_length == '0) begin
              found_q <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_START_RD;
            end
          end
        end
        ST_START_RD: begin
          state_q <= ST_START_CMP;
        end
        ST_START_CMP: begin
          if (match) begin
            depth_q <= LEN_W'(1);
            state_q <= ST_STEP;
          end else if (start_last) begin
            found_q <= 1'b0;
            state_q <= ST_DONE;
          end else begin
            r_q     <= adv_r;
            c_q     <= adv_c;
            state_q <= ST_START_RD;
          end
        end
        ST_STEP: begin
          if (word_done) begin
            found_q <= 1'b1;
            state_q <= ST_UNWIND;
          end else if (top_dir == gwp_pkg::DIR_DONE) begin
            depth_q <= depth_q - LEN_W'(1);
            if (depth_q == LEN_W'(1)) begin
              if (start_last) begin
                found_q <= 1'b0;
                state_q <= ST_DONE;
              end else begin
                r_q     <= adv_r;
                c_q     <= adv_c;
                state_q <= ST_START_RD;
              end
            end
          end else if (nb_ok) begin
            next_q  <= nb_cell;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (push) begin
            depth_q <= depth_q + LEN_W'(1);
          end
          state_q <= ST_STEP;
        end
        ST_UNWIND: begin
          depth_q <= depth_q - LEN_W'(1);
          if (depth_q == LEN_W'(1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res_valid_q || res_o.ready) begin
            res_valid_q <= 1'b1;
            res_found_q <= found_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/gwp_checker.sv */
// Port checker for the grid word path search unit, with its bind statement.
// Depends on gwp_pkg and on grid_word_path_search_unit.
module gwp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cmd_valid_i,
  input logic       cmd_ready_i,
  input logic [1:0] cmd_command_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       res_found_i
);

  logic cmd_acc;
  assign cmd_acc = cmd_valid_i && cmd_ready_i;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_found_i))
    else $error("result word dropped or changed while stalled");

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && cmd_command_i == gwp_pkg::CMD_SEARCH |=> !cmd_ready_i)
    else $error("command taken in the cycle after a search");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && cmd_command_i != gwp_pkg::CMD_SEARCH && !res_valid_i |=> !res_valid_i)
    else $error("result word without a search");

  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> !$past(cmd_ready_i))
    else $error("result word appeared while idle");

endmodule

bind grid_word_path_search_unit gwp_checker u_gwp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .cmd_command_i (cmd_i.data.command),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_found_i   (res_o.data.found)
);
